// File: rtl/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg: shared types and constants of the MAC address packet filter
// Item and result payloads, address table requests, mode and register codes.
// ----------------------------------------------------------------------------
package maf_pkg;

  // Slots in each of the three address tables
  localparam int unsigned TableDepth = 16;
  localparam int unsigned AddrW      = 48;
  localparam int unsigned CountW     = 32;
  localparam int unsigned ItemModeW  = 3;
  localparam int unsigned FiltModeW  = 2;
  localparam int unsigned CfgIndexW  = 2;

  // Per-table filter mode register coding; code three acts as unused
  typedef enum logic [FiltModeW-1:0] {
    FILT_UNUSED = 2'd0,
    FILT_NORMAL = 2'd1,
    FILT_INVERT = 2'd2
  } filt_mode_e;

  // Item mode field coding; codes five to seven are ignored
  typedef enum logic [ItemModeW-1:0] {
    MODE_FILTER     = 3'd0,
    MODE_INS_BSSID  = 3'd1,
    MODE_INS_SOURCE = 3'd2,
    MODE_INS_DEST   = 3'd3,
    MODE_INS_ALL    = 3'd4
  } item_mode_e;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_BSSID_MODE  = 2'd0,
    REG_SOURCE_MODE = 2'd1,
    REG_DEST_MODE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ItemModeW-1:0] mode;
    logic [AddrW-1:0]     bssid_address;
    logic [AddrW-1:0]     source_address;
    logic [AddrW-1:0]     dest_address;
    logic [AddrW-1:0]     entry_address;
  } item_t;

  typedef struct packed {
    logic              frame_hit;
    logic              bssid_table_hit;
    logic              source_table_hit;
    logic              dest_table_hit;
    logic              table_full;
    logic [CountW-1:0] bssid_hit_total;
    logic [CountW-1:0] source_hit_total;
    logic [CountW-1:0] dest_hit_total;
  } result_t;

  // Lookup / insert request to one address table
  typedef struct packed {
    logic             ins;
    logic [AddrW-1:0] key;
  } tab_req_t;

  // Table answer: key present, insert dropped for lack of room
  typedef struct packed {
    logic present;
    logic drop;
  } tab_rsp_t;

endpackage

// File: rtl/mac_address_packet_filter.sv
// ----------------------------------------------------------------------------
// mac_address_packet_filter: three-table exact-match MAC address filter
// Keeps BSSID, source and destination tables; scores frames and counts hits.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  --------  -------------------------  -------------------------------
//  item in   start & !busy              item_i   (maf_pkg::item_t)
//  result    result_valid_o, 1 cycle    result_o (maf_pkg::result_t)
//  config    cfg_we_i, no wait          cfg_index_i, cfg_wdata_i
//
//  An item accepted into the input register is scored, then registered in the result
//  register and held on result_o for exactly one cycle, when the result transfers.
//  busy stays low: a new item can enter every cycle, and each item sees the
//  tables and counters as left by the one before.
//  The depth is set by the input register and the result register around the
//  table compare. The receiver cannot stall, so no result is ever held.
//  Reset clears valid bits, counters and mode registers; no clearing pass.
//
module mac_address_packet_filter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  maf_pkg::item_t    item_i,
  output logic              result_valid_o,
  output maf_pkg::result_t  result_o,
  input  logic              cfg_we_i,
  input  logic [maf_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [maf_pkg::FiltModeW-1:0] cfg_wdata_i
);
  import maf_pkg::*;

  // Normal mode hits on absence, inverted mode on presence
  function automatic logic score(filt_mode_e m, logic present);
    logic hit;
    unique case (m)
      FILT_NORMAL: hit = !present;
      FILT_INVERT: hit = present;
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] c, logic en);
    logic [CountW-1:0] r;
    r = (en && (c != '1)) ? c + CountW'(1) : c;
    return r;
  endfunction

  filt_mode_e bssid_mode_q, source_mode_q, dest_mode_q;

  logic              valid_q;
  item_t             item_q;
  logic              accept;

  logic              is_filter;
  logic              ins_b, ins_s, ins_d;
  tab_req_t          req_b, req_s, req_d;
  tab_rsp_t          rsp_b, rsp_s, rsp_d;
  logic              hit_b, hit_s, hit_d;

  logic [CountW-1:0] cnt_b_q, cnt_s_q, cnt_d_q;
  logic [CountW-1:0] cnt_b_d, cnt_s_d, cnt_d_d;

  logic              result_valid_q;
  result_t           result_q, result_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration: unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bssid_mode_q  <= FILT_UNUSED;
      source_mode_q <= FILT_UNUSED;
      dest_mode_q   <= FILT_UNUSED;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BSSID_MODE:  bssid_mode_q  <= filt_mode_e'(cfg_wdata_i);
        REG_SOURCE_MODE: source_mode_q <= filt_mode_e'(cfg_wdata_i);
        REG_DEST_MODE:   dest_mode_q   <= filt_mode_e'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  // Decode the item: filters compare frame addresses, inserts the entry
  assign is_filter = valid_q && (item_q.mode == MODE_FILTER);
  assign ins_b = valid_q && ((item_q.mode == MODE_INS_BSSID)  || (item_q.mode == MODE_INS_ALL));
  assign ins_s = valid_q && ((item_q.mode == MODE_INS_SOURCE) || (item_q.mode == MODE_INS_ALL));
  assign ins_d = valid_q && ((item_q.mode == MODE_INS_DEST)   || (item_q.mode == MODE_INS_ALL));

  assign req_b.ins = ins_b;
  assign req_b.key = is_filter ? item_q.bssid_address : item_q.entry_address;
  assign req_s.ins = ins_s;
  assign req_s.key = is_filter ? item_q.source_address : item_q.entry_address;
  assign req_d.ins = ins_d;
  assign req_d.key = is_filter ? item_q.dest_address : item_q.entry_address;

  maf_table u_bssid_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_b),
    .rsp_o  (rsp_b)
  );

  maf_table u_source_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_s),
    .rsp_o  (rsp_s)
  );

  maf_table u_dest_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_d),
    .rsp_o  (rsp_d)
  );

  // Score each table, only for filter items
  assign hit_b = is_filter && score(bssid_mode_q, rsp_b.present);
  assign hit_s = is_filter && score(source_mode_q, rsp_s.present);
  assign hit_d = is_filter && score(dest_mode_q, rsp_d.present);

  // Advance the hit counters; hold at all ones
  assign cnt_b_d = sat_inc(cnt_b_q, hit_b);
  assign cnt_s_d = sat_inc(cnt_s_q, hit_s);
  assign cnt_d_d = sat_inc(cnt_d_q, hit_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_b_q <= '0;
      cnt_s_q <= '0;
      cnt_d_q <= '0;
    end else begin
      cnt_b_q <= cnt_b_d;
      cnt_s_q <= cnt_s_d;
      cnt_d_q <= cnt_d_d;
    end
  end

  // Result register: one transfer per accepted item
  always_comb begin
    result_d.frame_hit        = hit_b || hit_s || hit_d;
    result_d.bssid_table_hit  = hit_b;
    result_d.source_table_hit = hit_s;
    result_d.dest_table_hit   = hit_d;
    result_d.table_full       = rsp_b.drop || rsp_s.drop || rsp_d.drop;
    result_d.bssid_hit_total  = cnt_b_d;
    result_d.source_hit_total = cnt_s_d;
    result_d.dest_hit_total   = cnt_d_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// File: rtl/maf_table.sv
// ----------------------------------------------------------------------------
// maf_table: one exact-match address table
// Parallel compare over all valid slots; insert fills the lowest free slot.
// ----------------------------------------------------------------------------
module maf_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  maf_pkg::tab_req_t req_i,
  output maf_pkg::tab_rsp_t rsp_o
);
  import maf_pkg::*;

  logic [AddrW-1:0]      entry_q [TableDepth];
  logic [TableDepth-1:0] valid_q;
  logic [TableDepth-1:0] match;
  logic [TableDepth-1:0] free;
  logic [TableDepth-1:0] first_free;
  logic                  present;
  logic                  full;
  logic                  ins_ok;

  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      match[i] = valid_q[i] && (entry_q[i] == req_i.key);
    end
  end

  // Isolate the lowest clear valid bit
  assign free       = ~valid_q;
  assign first_free = free & (~free + TableDepth'(1));
  assign present    = |match;
  assign full       = &valid_q;
  assign ins_ok     = req_i.ins && !present && !full;

  assign rsp_o.present = present;
  assign rsp_o.drop    = req_i.ins && !present && full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ins_ok) begin
      valid_q <= valid_q | first_free;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TableDepth; i++) begin
      if (ins_ok && first_free[i]) begin
        entry_q[i] <= req_i.key;
      end
    end
  end

endmodule
